### hw/rtl/hlsrgb_pkg.sv
// Shared constants, stage-advance type and hue ramp helper for the HLS to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hlsrgb_pkg;

   // Field widths
   localparam int HUE_W    = 13;
   localparam int FIELD_W  = 13;
   localparam int CHAN_W   = 8;
   localparam int RAMP_W   = 10;

   // Hue breakpoints in 1/16 degree units
   localparam logic [HUE_W-1:0] HUE_FULL     = 13'd5760;
   localparam logic [HUE_W-1:0] HUE_THIRD    = 13'd1920;
   localparam logic [HUE_W-1:0] HUE_RISE_END = 13'd960;
   localparam logic [HUE_W-1:0] HUE_FLAT_END = 13'd2880;
   localparam logic [HUE_W-1:0] HUE_FALL_END = 13'd3840;

   // Load strobes for the stage registers after the input stage
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } hlsrgb_adv_type;

   // Weight of (m2 - m1) for one channel hue, in 1/16 degree units up to 960 (sixty degrees)
   function automatic logic [RAMP_W-1:0] ramp_weight(input logic [HUE_W-1:0] h);
      logic [HUE_W-1:0] fall;
      fall = HUE_FALL_END - h;
      if (h < HUE_RISE_END) begin
         return h[RAMP_W-1:0];
      end else if (h < HUE_FLAT_END) begin
         return HUE_RISE_END[RAMP_W-1:0];
      end else if (h < HUE_FALL_END) begin
         return fall[RAMP_W-1:0];
      end else begin
         return '0;
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hlsrgb_channel.sv
// One colour channel: hue ramp weight, ramp multiply and scaling to eight bits.
`timescale 1ns / 1ps
`default_nettype none

module hlsrgb_channel
   import hlsrgb_pkg::*;
#(
   parameter int FRACTION_BITS = 12
)
(
   input  wire logic                            clock,
   input  wire hlsrgb_adv_type                  adv,
   input  wire logic [HUE_W-1:0]                hue,      // stage 1
   input  wire logic [2*FRACTION_BITS+1:0]      delta,    // stage 3, m2 - m1
   input  wire logic [2*FRACTION_BITS+11:0]     base,     // stage 4, m1 * 960
   output logic      [CHAN_W-1:0]               channel   // stage 5
);

   localparam int PW = 2 * FRACTION_BITS + 2;
   localparam int NW = PW + 10;
   localparam int XW = NW + 5;

   logic [RAMP_W-1:0] weight2_ff;
   logic [RAMP_W-1:0] weight3_ff;
   logic [NW-1:0]     prod4_ff;
   logic [NW-1:0]     prod4_in;
   logic [NW-1:0]     num;
   logic [XW-1:0]     scaled;
   logic [CHAN_W-1:0] chan5_ff;
   logic [CHAN_W-1:0] chan5_in;

   // Ramp product, then scale by 255/960 = 17/64 and drop the fraction
   always_comb begin
      prod4_in = NW'(delta) * NW'(weight3_ff);
      num      = base + prod4_ff;
      scaled   = (XW'(num) << 4) + XW'(num);
      chan5_in = scaled[2*FRACTION_BITS+13 : 2*FRACTION_BITS+6];
   end

   // Advance the channel stages with the shared strobes
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         weight2_ff <= ramp_weight(hue);
      end
      if (adv.s3) begin
         weight3_ff <= weight2_ff;
      end
      if (adv.s4) begin
         prod4_ff <= prod4_in;
      end
      if (adv.s5) begin
         chan5_ff <= chan5_in;
      end
   end

   assign channel = chan5_ff;

endmodule

`default_nettype wire

### hw/rtl/hls_to_rgb_converter.sv
// Top level of the HLS to RGB converter: clamping, m1/m2 datapath and pipeline control.
//
//  channel | direction | tdata fields (low bit up)                      | tuser
//  req     | in        | hue[12:0], lightness[25:13], saturation[38:26] | none
//  rsp     | out       | red[7:0], green[15:8], blue[23:16]             | none
//
//  rsp_tvalid rises when an accepted req transaction reaches the output register;
//  one transaction enters per cycle unless the output stalls. The stages are clamp
//  and hue offset, l*s multiply, m1/m2 add, ramp multiply, scale and output register.
//  Each stage holds while its successor is full and stalled, so empty stages
//  still fill while a result waits; req_tready follows rsp_tready through this chain.
//  reset clears only the stage valid bits; data registers carry no reset.
`timescale 1ns / 1ps
`default_nettype none

module hls_to_rgb_converter
   import hlsrgb_pkg::*;
#(
   parameter int FRACTION_BITS = 12
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // hue[12:0], lightness[25:13], saturation[38:26]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   localparam int LW = FRACTION_BITS + 1;
   localparam int PW = 2 * LW;
   localparam int XW = (LW > FIELD_W) ? LW : FIELD_W;
   localparam logic [XW-1:0] ONE_X = XW'(1) << FRACTION_BITS;

   // Stage valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   hlsrgb_adv_type adv;

   // Stage 1
   logic [HUE_W-1:0] hue_c, hr_in, hb_in;
   logic [XW-1:0]    l_x, s_x;
   logic [HUE_W-1:0] hg1_ff, hr1_ff, hb1_ff;
   logic [LW-1:0]    l1_ff, s1_ff, l1_in, s1_in;
   // Stage 2
   logic [PW-1:0]    ls2_ff, ls2_in;
   logic [LW-1:0]    l2_ff, s2_ff;
   logic             low2_ff, low2_in;
   // Stage 3
   logic [PW-1:0]    m2_c, l_one, m1_in, d_in;
   logic [PW-1:0]    m1_3_ff, d3_ff;
   // Stage 4
   logic [PW+9:0]    base4_ff, base4_in;
   // Stage 5
   logic [CHAN_W-1:0] red, green, blue;

   // Ready chain: a stage loads when empty or when its successor moves on
   always_comb begin
      rdy5 = !v5_ff || rsp_tready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      v5_in = rdy5 ? v4_ff : v5_ff;
      adv.s2 = rdy2;
      adv.s3 = rdy3;
      adv.s4 = rdy4;
      adv.s5 = rdy5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Stage 1: clamp inputs and form the offset hues for red and blue
   always_comb begin
      hue_c = (req_tdata[12:0] > HUE_FULL) ? HUE_FULL : req_tdata[12:0];
      hr_in = hue_c + HUE_THIRD;
      if (hr_in > HUE_FULL) begin
         hr_in = hr_in - HUE_FULL;
      end
      hb_in = (hue_c >= HUE_THIRD) ? (hue_c - HUE_THIRD) : (hue_c + (HUE_FULL - HUE_THIRD));
      l_x   = XW'(req_tdata[25:13]);
      s_x   = XW'(req_tdata[38:26]);
      l1_in = (l_x > ONE_X) ? LW'(ONE_X) : LW'(l_x);
      s1_in = (s_x > ONE_X) ? LW'(ONE_X) : LW'(s_x);
   end

   // Stage 2: l*s product and lightness split
   always_comb begin
      ls2_in  = PW'(l1_ff) * PW'(s1_ff);
      low2_in = (PW'({l1_ff, 1'b0}) <= (PW'(1) << FRACTION_BITS));
   end

   // Stage 3: m2, m1 and the ramp span m2 - m1
   always_comb begin
      l_one = PW'(l2_ff) << FRACTION_BITS;
      if (low2_ff) begin
         m2_c = l_one + ls2_ff;
      end else begin
         m2_c = l_one + (PW'(s2_ff) << FRACTION_BITS) - ls2_ff;
      end
      m1_in = (l_one << 1) - m2_c;
      d_in  = m2_c - m1_in;
   end

   // Stage 4: m1 * 960 as shift and subtract
   always_comb begin
      base4_in = ((PW + 10)'(m1_3_ff) << 10) - ((PW + 10)'(m1_3_ff) << 6);
   end

   // Advance the shared data stages
   always_ff @(posedge clock) begin
      if (rdy1) begin
         hg1_ff <= hue_c;
         hr1_ff <= hr_in;
         hb1_ff <= hb_in;
         l1_ff  <= l1_in;
         s1_ff  <= s1_in;
      end
      if (rdy2) begin
         ls2_ff  <= ls2_in;
         l2_ff   <= l1_ff;
         s2_ff   <= s1_ff;
         low2_ff <= low2_in;
      end
      if (rdy3) begin
         m1_3_ff <= m1_in;
         d3_ff   <= d_in;
      end
      if (rdy4) begin
         base4_ff <= base4_in;
      end
   end

   // One ramp per channel
   hlsrgb_channel #(.FRACTION_BITS(FRACTION_BITS)) u_red (
      .clock   (clock),
      .adv     (adv),
      .hue     (hr1_ff),
      .delta   (d3_ff),
      .base    (base4_ff),
      .channel (red)
   );

   hlsrgb_channel #(.FRACTION_BITS(FRACTION_BITS)) u_green (
      .clock   (clock),
      .adv     (adv),
      .hue     (hg1_ff),
      .delta   (d3_ff),
      .base    (base4_ff),
      .channel (green)
   );

   hlsrgb_channel #(.FRACTION_BITS(FRACTION_BITS)) u_blue (
      .clock   (clock),
      .adv     (adv),
      .hue     (hb1_ff),
      .delta   (d3_ff),
      .base    (base4_ff),
      .channel (blue)
   );

   assign req_tready = rdy1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {blue, green, red};

   // An empty output stage leaves the whole pipeline free to accept
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !v5_ff |-> req_tready)
      else $error("req_tready low while output stage empty");

   // An accepted transaction lands in the first stage
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted transaction lost at stage 1");

   // A blocked first stage keeps its item
   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !rdy2) |=> (v1_ff && $stable(hg1_ff) && $stable(l1_ff)))
      else $error("stage 1 changed while stalled");

endmodule

`default_nettype wire
